>>> hw/rtl/isem_pkg.sv
// ----------------------------------------------------------------------------
// isem_pkg
// Shared types and constants of the 3-D Ising energy / magnetization unit.
// ----------------------------------------------------------------------------
`default_nettype none

package isem_pkg;

    // Lattice geometry
    localparam int MAX_SIDE  = 16;
    localparam int COORD_W   = 4;
    localparam int SIDE_W    = 5;
    localparam int ADDR_W    = 3 * COORD_W;
    localparam int SITES     = MAX_SIDE * MAX_SIDE * MAX_SIDE;

    // Payload widths
    localparam int SITE_E_W  = 4;
    localparam int TOTAL_E_W = 15;
    localparam int MAG_W     = 14;

    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(16);

    // Request kinds
    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_MEASURE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_MEASURE,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Which site of the neighbourhood a read fetches
    typedef enum logic [2:0] {
        NBR_CENTRE = 3'd0,
        NBR_XM     = 3'd1,
        NBR_XP     = 3'd2,
        NBR_YM     = 3'd3,
        NBR_YP     = 3'd4,
        NBR_ZM     = 3'd5,
        NBR_ZP     = 3'd6
    } t_nbr;

endpackage

`default_nettype wire

>>> hw/rtl/isem_if.sv
// ----------------------------------------------------------------------------
// isem_req_if / isem_res_if
// Valid/ready channels carrying requests into and results out of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface isem_req_if import isem_pkg::*;;
    logic                 valid;
    logic                 ready;
    t_action              action;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COORD_W-1:0]   coord_z;
    logic                 spin_up;

    modport source (output valid, action, coord_x, coord_y, coord_z, spin_up,
                    input  ready);
    modport sink   (input  valid, action, coord_x, coord_y, coord_z, spin_up,
                    output ready);
endinterface

interface isem_res_if import isem_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [SITE_E_W-1:0]  site_energy;
    logic signed [TOTAL_E_W-1:0] total_energy;
    logic signed [MAG_W-1:0]     magnetization;

    modport source (output valid, site_energy, total_energy, magnetization,
                    input  ready);
    modport sink   (input  valid, site_energy, total_energy, magnetization,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/isem_ram.sv
// ----------------------------------------------------------------------------
// isem_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module isem_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ising3d_energy_magnetization_unit.sv
// Write request: one per cycle while idle.
// Site query: one spin-store read per cycle for the site and its six neighbours,
//   result registered in ST_DONE after ST_DRAIN, once the output register is free.
// Measure: four reads per site (site, +x, +y, +z), result after the last reads drain.
// Reset: a clearing pass writes all 4096 sites to spin up; no request is taken
//   meanwhile, side register writes are. Side register resets to 16.
// ----------------------------------------------------------------------------
// ising3d_energy_magnetization_unit
// Cubic Ising lattice with periodic wrap: spin writes, site energy queries and
// whole-lattice energy / magnetization measures over a simple dual-port spin store.
// ----------------------------------------------------------------------------
`default_nettype none

module ising3d_energy_magnetization_unit import isem_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [SIDE_W-1:0] i_cfg_wr_data,
    isem_req_if.sink               i_req,
    isem_res_if.source             o_res
);

    // wrap helpers on the side in use
    function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] c,
                                                    input logic [SIDE_W-1:0]  side);
        logic [SIDE_W-1:0] s;
        s = {1'b0, c} + SIDE_W'(1);
        return (s == side) ? '0 : s[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] c,
                                                    input logic [SIDE_W-1:0]  side);
        logic [SIDE_W-1:0] s;
        s = side - SIDE_W'(1);
        return (c == '0) ? s[COORD_W-1:0] : c - COORD_W'(1);
    endfunction

    // registers
    t_state                      r_state, n_state;
    logic [SIDE_W-1:0]           r_side;
    logic [ADDR_W-1:0]           r_clr_addr, n_clr_addr;
    logic [2:0]                  r_step, n_step;
    logic [COORD_W-1:0]          r_x, n_x, r_y, n_y, r_z, n_z;
    logic                        r_is_query, n_is_query;
    logic                        r_rd_vld, n_rd_vld;
    logic                        r_rd_centre, n_rd_centre;
    logic                        r_centre, n_centre;
    logic [2:0]                  r_diff, n_diff;
    logic signed [TOTAL_E_W-1:0] r_esum, n_esum;
    logic signed [MAG_W-1:0]     r_mag, n_mag;
    logic                        r_out_valid, n_out_valid;
    logic signed [SITE_E_W-1:0]  r_out_site, n_out_site;
    logic signed [TOTAL_E_W-1:0] r_out_total, n_out_total;
    logic signed [MAG_W-1:0]     r_out_mag, n_out_mag;

    // combinational
    logic [SIDE_W-1:0]  side_use;
    logic [COORD_W-1:0] side_m1;
    logic               req_take;
    logic               req_inside;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_data;
    logic               rd_en;
    t_nbr               rd_nbr;
    logic [COORD_W-1:0] ax, ay, az;
    logic               rd_data;
    logic               differ;

    // side in use, saturated into [2, MAX_SIDE]
    always_comb begin
        if (r_side < SIDE_MIN) begin
            side_use = SIDE_MIN;
        end else if (r_side > SIDE_MAX) begin
            side_use = SIDE_MAX;
        end else begin
            side_use = r_side;
        end
        side_m1 = COORD_W'(side_use - SIDE_W'(1));
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign req_inside  = ({1'b0, i_req.coord_x} < side_use) &&
                         ({1'b0, i_req.coord_y} < side_use) &&
                         ({1'b0, i_req.coord_z} < side_use);

    // neighbour address of the current read
    always_comb begin
        ax = r_x;
        ay = r_y;
        az = r_z;
        case (rd_nbr)
            NBR_CENTRE: ;
            NBR_XM:     ax = wrap_dec(r_x, side_use);
            NBR_XP:     ax = wrap_inc(r_x, side_use);
            NBR_YM:     ay = wrap_dec(r_y, side_use);
            NBR_YP:     ay = wrap_inc(r_y, side_use);
            NBR_ZM:     az = wrap_dec(r_z, side_use);
            NBR_ZP:     az = wrap_inc(r_z, side_use);
            default:    ;
        endcase
    end

    // spin store
    isem_ram #(
        .WIDTH (1),
        .DEPTH (SITES)
    ) u_spin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr ({ax, ay, az}),
        .o_rd_data (rd_data)
    );

    assign differ = rd_data != r_centre;

    // sequencer: next state, store access, accumulation
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_step      = r_step;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_is_query  = r_is_query;
        n_centre    = r_centre;
        n_diff      = r_diff;
        n_esum      = r_esum;
        n_mag       = r_mag;
        n_out_valid = r_out_valid;
        n_out_site  = r_out_site;
        n_out_total = r_out_total;
        n_out_mag   = r_out_mag;
        wr_en       = 1'b0;
        wr_addr     = {i_req.coord_x, i_req.coord_y, i_req.coord_z};
        wr_data     = i_req.spin_up;
        rd_en       = 1'b0;
        rd_nbr      = NBR_CENTRE;

        // result taken downstream
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = 1'b1;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_take) begin
                    case (i_req.action)
                        ACT_WRITE: begin
                            wr_en = req_inside;
                        end
                        ACT_QUERY: begin
                            n_x        = i_req.coord_x;
                            n_y        = i_req.coord_y;
                            n_z        = i_req.coord_z;
                            n_is_query = 1'b1;
                            n_step     = '0;
                            if (req_inside) begin
                                n_diff  = '0;
                                n_state = ST_QUERY;
                            end else begin
                                // three mismatches give a zero energy
                                n_diff  = 3'd3;
                                n_state = ST_DONE;
                            end
                        end
                        ACT_MEASURE: begin
                            n_x        = '0;
                            n_y        = '0;
                            n_z        = '0;
                            n_is_query = 1'b0;
                            n_step     = '0;
                            n_esum     = '0;
                            n_mag      = '0;
                            n_state    = ST_MEASURE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_QUERY: begin
                rd_en  = 1'b1;
                rd_nbr = t_nbr'(r_step);
                n_step = r_step + 3'd1;
                if (r_step == 3'(NBR_ZP)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_MEASURE: begin
                // site, then +x, +y, +z: each bond seen once
                rd_en  = 1'b1;
                rd_nbr = t_nbr'({r_step[1:0], 1'b0});
                n_step = r_step + 3'd1;
                if (r_step == 3'd3) begin
                    n_step = '0;
                    n_z    = wrap_inc(r_z, side_use);
                    if (r_z == side_m1) begin
                        n_y = wrap_inc(r_y, side_use);
                        if (r_y == side_m1) begin
                            n_x = wrap_inc(r_x, side_use);
                            if (r_x == side_m1) begin
                                n_state = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    if (r_is_query) begin
                        n_out_site  = SITE_E_W'({1'b0, r_diff, 1'b0}) - SITE_E_W'(6);
                        n_out_total = '0;
                        n_out_mag   = '0;
                    end else begin
                        n_out_site  = '0;
                        n_out_total = r_esum;
                        n_out_mag   = r_mag;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // read data returns in the cycle after issue
        n_rd_vld    = rd_en;
        n_rd_centre = rd_en && (rd_nbr == NBR_CENTRE);
        if (r_rd_vld) begin
            if (r_rd_centre) begin
                n_centre = rd_data;
                if (!r_is_query) begin
                    n_mag = rd_data ? r_mag + MAG_W'(1) : r_mag - MAG_W'(1);
                end
            end else if (r_is_query) begin
                n_diff = r_diff + 3'(differ);
            end else begin
                n_esum = differ ? r_esum + TOTAL_E_W'(1) : r_esum - TOTAL_E_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_side      <= SIDE_RESET;
            r_rd_vld    <= 1'b0;
            r_rd_centre <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_vld    <= n_rd_vld;
            r_rd_centre <= n_rd_centre;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_side <= i_cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_is_query  <= n_is_query;
        r_centre    <= n_centre;
        r_diff      <= n_diff;
        r_esum      <= n_esum;
        r_mag       <= n_mag;
        r_out_site  <= n_out_site;
        r_out_total <= n_out_total;
        r_out_mag   <= n_out_mag;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.site_energy   = r_out_site;
    assign o_res.total_energy  = r_out_total;
    assign o_res.magnetization = r_out_mag;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3-D Ising energy / magnetization unit. A local
// lattice model predicts every query and measure result from the requests
// the unit accepts. Each result is checked field by field in order. Directed
// checks cover the cold start, the wrap at the cube faces, side saturation
// and ignored requests. Random phases at many lattice sides follow, with
// idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import isem_pkg::*;

    typedef struct {
        logic signed [SITE_E_W-1:0]  site_energy;
        logic signed [TOTAL_E_W-1:0] total_energy;
        logic signed [MAG_W-1:0]     magnetization;
    } t_lattice_result;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIDE_W-1:0] cfg_wr_data;

    isem_req_if req_ch();
    isem_res_if res_ch();

    ising3d_energy_magnetization_unit DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_res         (res_ch)
    );

    // Lattice model: one spin bit per site and the side register
    bit                lattice_spin [SITES];
    logic [SIDE_W-1:0] side_reg;
    t_lattice_result   awaited_results [$];

    int  mismatch_count = 0;
    int  live_items     = 0;
    int  n_writes       = 0;
    int  n_queries      = 0;
    int  n_measures     = 0;
    int  n_side_writes  = 0;
    int  res_stall_left = 0;
    bit  calm           = 1'b0;

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Run limit
    initial begin
        #3000000;
        $display("ising3d_energy_magnetization_unit verification failed");
        $finish;
    end

    function automatic int effective_side();
        if (side_reg < SIDE_MIN) return int'(SIDE_MIN);
        if (side_reg > SIDE_MAX) return int'(SIDE_MAX);
        return int'(side_reg);
    endfunction

    function automatic int site_addr(int x, int y, int z);
        return (x * MAX_SIDE + y) * MAX_SIDE + z;
    endfunction

    // Minus the bond sum: differing neighbours count +1, equal ones -1
    function automatic int site_energy_of(int x, int y, int z, int s);
        int diff;
        bit c;
        diff = 0;
        c = lattice_spin[site_addr(x, y, z)];
        diff += int'(lattice_spin[site_addr((x + s - 1) % s, y, z)] != c);
        diff += int'(lattice_spin[site_addr((x + 1) % s, y, z)] != c);
        diff += int'(lattice_spin[site_addr(x, (y + s - 1) % s, z)] != c);
        diff += int'(lattice_spin[site_addr(x, (y + 1) % s, z)] != c);
        diff += int'(lattice_spin[site_addr(x, y, (z + s - 1) % s)] != c);
        diff += int'(lattice_spin[site_addr(x, y, (z + 1) % s)] != c);
        return 2 * diff - 6;
    endfunction

    function automatic longint clamp_to(longint v, int width);
        longint lo;
        longint hi;
        lo = -(longint'(1) << (width - 1));
        hi = (longint'(1) << (width - 1)) - 1;
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Apply one accepted request to the model and queue any result it gives
    function automatic void predict_request(t_action act, int x, int y, int z, bit up);
        int              s;
        bit              in_cube;
        longint          esum;
        longint          ups;
        t_lattice_result r;
        s = effective_side();
        in_cube = (x < s) && (y < s) && (z < s);
        r.site_energy   = '0;
        r.total_energy  = '0;
        r.magnetization = '0;
        live_items++;
        case (act)
            ACT_WRITE: begin
                if (in_cube) begin
                    lattice_spin[site_addr(x, y, z)] = up;
                    n_writes++;
                end
            end
            ACT_QUERY: begin
                if (in_cube) r.site_energy = SITE_E_W'(site_energy_of(x, y, z, s));
                awaited_results.push_back(r);
                n_queries++;
            end
            ACT_MEASURE: begin
                esum = 0;
                ups  = 0;
                for (int i = 0; i < s; i++)
                    for (int j = 0; j < s; j++)
                        for (int k = 0; k < s; k++) begin
                            esum += site_energy_of(i, j, k, s);
                            ups  += lattice_spin[site_addr(i, j, k)];
                        end
                r.total_energy  = TOTAL_E_W'(clamp_to(esum / 2, TOTAL_E_W));
                r.magnetization = MAG_W'(clamp_to(2 * ups - s * s * s, MAG_W));
                awaited_results.push_back(r);
                n_measures++;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Send one request; valid stays high after acceptance for back-to-back use
    task automatic send_request(t_action act, int x, int y, int z, bit up);
        if (!calm && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.coord_x <= COORD_W'(x);
        req_ch.coord_y <= COORD_W'(y);
        req_ch.coord_z <= COORD_W'(z);
        req_ch.spin_up <= up;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predict_request(act, x & 15, y & 15, z & 15, up);
    endtask

    // Hold the request channel until every awaited result is in, then hold off
    task automatic wait_drain(int holdoff);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
        repeat (holdoff) @(posedge clk);
    endtask

    task automatic write_side(int value);
        wait_drain(12);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SIDE_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        side_reg = SIDE_W'(value);
        n_side_writes++;
    endtask

    // Result sink: random stall bursts, none once calm
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_stall_left > 0) begin
                res_ch.ready <= 1'b0;
                res_stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                res_stall_left = $urandom_range(0, 4);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Result check against the oldest awaited result
    always @(posedge clk) begin : result_check
        t_lattice_result want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with none awaited", res_ch.total_energy, 0);
            end else begin
                want = awaited_results.pop_front();
                if (res_ch.site_energy !== want.site_energy)
                    report_mismatch("site_energy", res_ch.site_energy, want.site_energy);
                if (res_ch.total_energy !== want.total_energy)
                    report_mismatch("total_energy", res_ch.total_energy,
                                    want.total_energy);
                if (res_ch.magnetization !== want.magnetization)
                    report_mismatch("magnetization", res_ch.magnetization,
                                    want.magnetization);
            end
        end
    end

    // Cold start: every spin up, side 16
    task automatic test_cold_start();
        send_request(ACT_MEASURE, 0, 0, 0, 1'b0);
        send_request(ACT_QUERY, 0, 0, 0, 1'b0);
        send_request(ACT_QUERY, 15, 15, 15, 1'b1);
    endtask

    // Flipped spins seen across the periodic faces, unused action
    task automatic test_wrap_neighbours();
        send_request(ACT_WRITE, 0, 0, 0, 1'b0);
        send_request(ACT_QUERY, 0, 0, 0, 1'b0);
        send_request(ACT_QUERY, 15, 0, 0, 1'b1);
        send_request(ACT_QUERY, 0, 15, 0, 1'b0);
        send_request(ACT_WRITE, 15, 15, 15, 1'b0);
        send_request(ACT_QUERY, 0, 0, 15, 1'b1);
        send_request(ACT_NONE, 7, 9, 3, 1'b1);
        send_request(ACT_WRITE, 0, 0, 0, 1'b1);
        send_request(ACT_QUERY, 15, 15, 15, 1'b0);
        send_request(ACT_MEASURE, 15, 15, 15, 1'b1);
    endtask

    // Side at the edges and beyond, writes and queries outside the cube
    task automatic test_side_limits();
        write_side(2);
        send_request(ACT_WRITE, 1, 1, 1, 1'b0);
        send_request(ACT_QUERY, 0, 1, 1, 1'b1);
        send_request(ACT_WRITE, 2, 0, 0, 1'b0);
        send_request(ACT_QUERY, 3, 0, 0, 1'b0);
        send_request(ACT_MEASURE, 0, 0, 0, 1'b0);
        write_side(0);
        send_request(ACT_MEASURE, 1, 1, 1, 1'b1);
        write_side(1);
        send_request(ACT_QUERY, 1, 1, 1, 1'b0);
        write_side(5);
        send_request(ACT_WRITE, 4, 4, 4, 1'b0);
        send_request(ACT_WRITE, 0, 5, 0, 1'b0);
        send_request(ACT_QUERY, 0, 4, 4, 1'b1);
        send_request(ACT_QUERY, 4, 4, 5, 1'b1);
        send_request(ACT_MEASURE, 0, 0, 0, 1'b1);
        write_side(31);
        send_request(ACT_QUERY, 15, 15, 15, 1'b0);
        write_side(17);
        send_request(ACT_WRITE, 15, 0, 0, 1'b0);
        send_request(ACT_QUERY, 0, 0, 0, 1'b1);
    endtask

    // Random phases: loader writes, domain rows, queries, rare measures
    task automatic test_random_traffic(int target);
        int      start_items;
        int      phase_len;
        int      s;
        int      r;
        int      x;
        int      y;
        int      z;
        bit      spin;
        t_action act;
        start_items = live_items;
        while (live_items - start_items < target) begin
            r = $urandom_range(0, 99);
            if (r < 70)      write_side($urandom_range(2, 8));
            else if (r < 85) write_side($urandom_range(9, 16));
            else             write_side($urandom_range(0, 31));
            s = effective_side();
            if (target - (live_items - start_items) < 250) calm = 1'b1;
            phase_len = $urandom_range(80, 180);
            for (int n = 0; n < phase_len; n++) begin
                r    = $urandom_range(0, 99);
                spin = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0) begin
                    x = $urandom_range(0, 15);
                    y = $urandom_range(0, 15);
                    z = $urandom_range(0, 15);
                end else begin
                    x = $urandom_range(0, s - 1);
                    y = $urandom_range(0, s - 1);
                    z = $urandom_range(0, s - 1);
                end
                if (r < 3 && s <= 8)  act = ACT_MEASURE;
                else if (r < 28)      act = ACT_QUERY;
                else if (r < 31)      act = ACT_NONE;
                else                  act = ACT_WRITE;
                if (act == ACT_WRITE && $urandom_range(0, 15) == 0) begin
                    // a whole row along z with one spin builds domain walls
                    for (int k = 0; k < s; k++)
                        send_request(ACT_WRITE, x, y, k, spin);
                end else begin
                    send_request(act, x, y, z, spin);
                end
                if (!calm && $urandom_range(0, 199) == 0) wait_drain(0);
            end
        end
    endtask

    // Test sequence
    initial begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.action  <= ACT_WRITE;
        req_ch.coord_x <= '0;
        req_ch.coord_y <= '0;
        req_ch.coord_z <= '0;
        req_ch.spin_up <= 1'b0;
        foreach (lattice_spin[i]) lattice_spin[i] = 1'b1;
        side_reg = SIDE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_cold_start();
        test_wrap_neighbours();
        wait_drain(0);
        test_side_limits();
        test_random_traffic(1700);

        wait_drain(20);
        $display("run covered %0d spin writes, %0d site queries, %0d lattice measures",
                 n_writes, n_queries, n_measures);
        $display("side register set %0d times, saturated values and both edges included",
                 n_side_writes);
        if (mismatch_count == 0) begin
            $display("ising3d_energy_magnetization_unit verification clean");
        end else begin
            $display("ising3d_energy_magnetization_unit verification failed");
        end
        $finish;
    end

endmodule
